// File: rtl/sld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

  localparam int KEY_W          = 24;
  localparam int FRAME_W        = 15;
  localparam int BYTE_W         = 8;
  localparam int FRAME_BYTES_DEF = 16;
  localparam int CFG_IDX_W      = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd1;

  // lfsr width codes
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_24 = 2'd2;

  localparam logic [FRAME_W-1:0] SIG_FRAME_MIN = 15'h7FFC;

  typedef logic [1:0]       wc_t;
  typedef logic [KEY_W-1:0] lfsr_t;

  typedef struct packed {
    logic  done;
    lfsr_t value;
  } jump_rsp_t;

  typedef struct packed {
    logic              done;
    lfsr_t             value;
    logic [BYTE_W-1:0] ks;
  } ks_rsp_t;

  function automatic wc_t width_code(input lfsr_t key);
    wc_t wc;
    if (key[23:16] != 8'h00) begin
      wc = WC_24;
    end else if (key[15:8] != 8'h00) begin
      wc = WC_16;
    end else begin
      wc = WC_8;
    end
    return wc;
  endfunction

  function automatic lfsr_t width_mask(input wc_t wc);
    lfsr_t m;
    case (wc)
      WC_8:    m = 24'h0000FF;
      WC_16:   m = 24'h00FFFF;
      default: m = 24'hFFFFFF;
    endcase
    return m;
  endfunction

  function automatic logic fb_bit(input lfsr_t v, input wc_t wc);
    logic b;
    case (wc)
      WC_8:    b = v[7] ^ v[5] ^ v[4] ^ v[3];
      WC_16:   b = v[15] ^ v[14] ^ v[12] ^ v[3];
      default: b = v[23] ^ v[22] ^ v[21] ^ v[16];
    endcase
    return b;
  endfunction

  function automatic lfsr_t lfsr_step(input lfsr_t v, input wc_t wc);
    lfsr_t m;
    lfsr_t vm;
    m  = width_mask(wc);
    vm = v & m;
    return {vm[KEY_W-2:0], fb_bit(vm, wc)} & m;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sld_keystream.sv
`timescale 1ns / 1ps
`default_nettype none

module sld_keystream
  import sld_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  input  wire lfsr_t init_value,
  input  wire wc_t   wc,
  output ks_rsp_t    rsp
);

  logic              busy_r;
  logic              done_r;
  logic [2:0]        cnt_r;
  lfsr_t             v_r;
  logic [BYTE_W-1:0] ks_r;

  // one lfsr step per cycle, msb of the keystream byte first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= init_value;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        ks_r  <= {ks_r[BYTE_W-2:0], fb_bit(v_r, wc)};
        v_r   <= lfsr_step(v_r, wc);
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = v_r;
  assign rsp.ks    = ks_r;

endmodule

`default_nettype wire

// File: rtl/sld_jump.sv
`timescale 1ns / 1ps
`default_nettype none

module sld_jump
  import sld_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire lfsr_t              key,
  input  wire wc_t                wc,
  input  wire logic [FRAME_W-1:0] frame,
  output jump_rsp_t               rsp
);

  localparam int STEPS_PER_FRAME = 8 * FRAME_BYTES;
  localparam int N_W             = FRAME_W + $clog2(STEPS_PER_FRAME + 1);
  localparam int COL_W           = $clog2(KEY_W);

  localparam logic [1:0] J_IDLE = 2'd0;
  localparam logic [1:0] J_MUL  = 2'd1;
  localparam logic [1:0] J_SQ   = 2'd2;
  localparam logic [1:0] J_COPY = 2'd3;

  logic [1:0]                  st_r;
  logic [N_W-1:0]              n_r;
  lfsr_t                       v_r;
  logic [KEY_W-1:0][KEY_W-1:0] p_r;
  logic [KEY_W-1:0][KEY_W-1:0] t_r;
  logic [COL_W-1:0]            col_r;
  lfsr_t                       mv_in;
  lfsr_t                       mv;

  // shared gf(2) matrix times vector: the state in the multiply step,
  // one column of the matrix while squaring
  always_comb begin
    mv_in = (st_r == J_SQ) ? p_r[col_r] : v_r;
    mv    = '0;
    for (int i = 0; i < KEY_W; i++) begin
      if (mv_in[i]) begin
        mv = mv ^ p_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= J_IDLE;
    end else begin
      case (st_r)
        J_IDLE: begin
          if (start) begin
            v_r <= key & width_mask(wc);
            n_r <= N_W'(frame) * N_W'(STEPS_PER_FRAME);
            for (int i = 0; i < KEY_W; i++) begin
              p_r[i] <= lfsr_step(lfsr_t'(1) << i, wc);
            end
            st_r <= J_MUL;
          end
        end
        J_MUL: begin
          if (n_r == '0) begin
            st_r <= J_IDLE;
          end else begin
            if (n_r[0]) begin
              v_r <= mv;
            end
            n_r   <= n_r >> 1;
            col_r <= '0;
            if ((n_r >> 1) != '0) begin
              st_r <= J_SQ;
            end
          end
        end
        J_SQ: begin
          t_r[col_r] <= mv;
          col_r      <= col_r + COL_W'(1);
          if (col_r == COL_W'(KEY_W - 1)) begin
            st_r <= J_COPY;
          end
        end
        J_COPY: begin
          p_r  <= t_r;
          st_r <= J_MUL;
        end
        default: st_r <= J_IDLE;
      endcase
    end
  end

  assign rsp.done  = (st_r == J_MUL) && (n_r == '0);
  assign rsp.value = v_r;

endmodule

`default_nettype wire

// File: rtl/stream_lfsr_descrambler_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// stream payload descrambler, one byte per request, FRAME_BYTES bytes a frame
// - cfg channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
//   the 24 bit key (its magnitude picks an 8, 16 or 24 bit lfsr), index 1 is
//   the enable; write only while the unit is idle
// - in channel: byte, frame number and signed flag; the frame number and
//   signed flag count only on the first byte of a frame
// - out channel: descrambled byte and a last-byte-of-frame flag, one result
//   request for every input request, in order
// - a byte passes from accept to out_valid through a decision state, eight
//   steps of the single lfsr step unit, a handoff and the output load; no
//   new request is taken before the result is loaded into the output
//   register; disabled or signature-frame bytes skip the steps
// - a skipped frame number costs a fast-forward on the shared 24x24 gf(2)
//   matrix unit: a multiply step for each bit of frame*8*FRAME_BYTES, with
//   the matrix squared column by column and copied back between the steps
// - in_stall is high whenever a request is in flight; the next request is
//   taken while a finished result still sits in the output register
// - out_stall holds the output register; the unit then waits with its next
//   result until the register drains
// - synchronous reset clears key, enable, lfsr, frame tracking and out_valid

module stream_lfsr_descrambler_unit
  import sld_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [BYTE_W-1:0]    in_payload_byte,
  input  wire logic [15:0]          in_frame_number,
  input  wire logic                 in_signed_stream,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [BYTE_W-1:0]         out_clear_byte,
  output logic                      out_frame_last
);

  localparam int POS_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_JUMP = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_KEY  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  lfsr_t              key_r;
  logic               en_r;
  lfsr_t              lfsr_r;
  logic [FRAME_W-1:0] exp_r;
  logic [POS_W-1:0]   pos_r;
  logic               ks_off_r;
  logic [BYTE_W-1:0]  data_r;
  logic               last_r;
  logic [BYTE_W-1:0]  ks_byte_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;

  wc_t                wc;
  logic               cfg_acc;
  logic               in_acc;
  logic               frame_start;
  logic [FRAME_W-1:0] frame;
  logic               jump_start;
  logic               ks_run;
  logic               ks_start;
  logic               out_free;
  logic               out_load;
  jump_rsp_t          jrsp;
  ks_rsp_t            krsp;

  // width follows the current key at once
  assign wc          = width_code(key_r);
  assign cfg_ready   = (state_r == S_IDLE);
  assign cfg_acc     = cfg_valid && cfg_ready;
  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign frame_start = (pos_r == '0);
  assign frame       = in_frame_number[FRAME_W-1:0];

  // skipped frame: restart from the key and fast-forward
  assign jump_start = in_acc && frame_start && en_r &&
                      (in_frame_number != 16'h0000) && (frame != exp_r);

  // signature frames and a disabled unit do not step the lfsr for keystream
  assign ks_run   = en_r && !ks_off_r;
  assign ks_start = (state_r == S_PREP) && ks_run;

  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_OUT) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = jump_start ? S_JUMP : S_PREP;
        end
      end
      S_JUMP: begin
        if (jrsp.done) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP:  state_nxt = ks_run ? S_KEY : S_OUT;
      S_KEY: begin
        if (krsp.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      key_r       <= '0;
      en_r        <= 1'b0;
      lfsr_r      <= '0;
      exp_r       <= '0;
      pos_r       <= '0;
      ks_off_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_acc) begin
        case (cfg_index)
          REG_KEY:    key_r <= cfg_data;
          REG_ENABLE: en_r  <= cfg_data[0];
          default:    ;
        endcase
      end

      if (in_acc) begin
        data_r <= in_payload_byte;
        last_r <= (pos_r == POS_LAST);
        pos_r  <= (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);
        if (frame_start) begin
          ks_off_r <= in_signed_stream && (frame >= SIG_FRAME_MIN);
          exp_r    <= frame + FRAME_W'(1);
          // frame zero reloads the key directly
          if (en_r && (in_frame_number == 16'h0000)) begin
            lfsr_r <= key_r & width_mask(wc);
          end
        end
      end

      if (jrsp.done && (state_r == S_JUMP)) begin
        lfsr_r <= jrsp.value;
      end

      if ((state_r == S_PREP) && !ks_run) begin
        ks_byte_r <= '0;
      end

      if (krsp.done) begin
        lfsr_r    <= krsp.value;
        ks_byte_r <= krsp.ks;
      end

      if (out_load) begin
        out_byte_r  <= data_r ^ ks_byte_r;
        out_last_r  <= last_r;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  sld_jump #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_jump (
    .clk  (clk),
    .rst_n(rst_n),
    .start(jump_start),
    .key  (key_r),
    .wc   (wc),
    .frame(frame),
    .rsp  (jrsp)
  );

  sld_keystream u_keystream (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ks_start),
    .init_value(lfsr_r),
    .wc        (wc),
    .rsp       (krsp)
  );

  assign out_valid      = out_valid_r;
  assign out_clear_byte = out_byte_r;
  assign out_frame_last = out_last_r;

  a_jump_done_in_jump: assert property (@(posedge clk) disable iff (!rst_n)
    jrsp.done |-> (state_r == S_JUMP || state_r == S_IDLE))
    else $error("fast-forward finished outside its wait state");

  a_ks_done_in_key: assert property (@(posedge clk) disable iff (!rst_n)
    krsp.done |-> (state_r == S_KEY))
    else $error("keystream byte finished outside its wait state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("result left before output register drained");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (pos_r <= POS_LAST))
    else $error("byte position past end of frame");

  a_jump_only_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    jump_start |-> (en_r && frame_start))
    else $error("fast-forward started mid-frame or while disabled");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// descrambler testbench: a short directed run (frame-zero reload, key width
// changes and an enable toggle inside a frame, the largest fast-forward on a
// signature frame), then random frame sequences under three idling profiles.
// a local predictor keeps its own copy of key, enable, lfsr and frame
// tracking; every accepted request queues one expected result, and a checker
// compares each accepted result against the oldest one in the queue

module tb_top;
  import sld_pkg::*;

  localparam int FRAME_LEN     = FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  // long enough to drain the pipe with room
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] clear_byte;
    logic              frame_last;
  } clear_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [KEY_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_payload_byte;
  logic [15:0]          in_frame_number;
  logic                 in_signed_stream;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BYTE_W-1:0]    out_clear_byte;
  logic                 out_frame_last;

  // predictor state, kept apart from the block
  lfsr_t              key_q;
  logic               enable_q;
  lfsr_t              lfsr_q;
  logic [FRAME_W-1:0] next_frame_q;
  int unsigned        pos_q;
  logic               ks_off_q;
  clear_t             clear_q[$];

  // idling profile, percent per cycle
  int gap_pct;
  int stall_pct;

  int unsigned err_count = 0;
  int unsigned sent_count;
  int unsigned got_count = 0;
  int unsigned frame_count;
  int unsigned leap_count;
  int unsigned sig_count;
  int unsigned cycle_count = 0;

  stream_lfsr_descrambler_unit #(
    .FRAME_BYTES(FRAME_LEN)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_payload_byte (in_payload_byte),
    .in_frame_number (in_frame_number),
    .in_signed_stream(in_signed_stream),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_clear_byte  (out_clear_byte),
    .out_frame_last  (out_frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // key magnitude picks the register width
  function automatic wc_t key_to_wc(input lfsr_t key);
    if (key > 24'h00FFFF) return WC_24;
    if (key > 24'h0000FF) return WC_16;
    return WC_8;
  endfunction

  function automatic lfsr_t wc_mask(input wc_t wc);
    lfsr_t m;
    m = 24'hFFFFFF;
    if (wc == WC_8) m = 24'h0000FF;
    else if (wc == WC_16) m = 24'h00FFFF;
    return m;
  endfunction

  // taps as bit masks: 8 bit 7,5,4,3 / 16 bit 15,14,12,3 / 24 bit 23,22,21,16
  function automatic lfsr_t tap_mask(input wc_t wc);
    lfsr_t t;
    t = 24'hE10000;
    if (wc == WC_8) t = 24'h0000B8;
    else if (wc == WC_16) t = 24'h00D008;
    return t;
  endfunction

  function automatic lfsr_t lfsr_next(input lfsr_t v, input wc_t wc);
    lfsr_t vm;
    vm = v & wc_mask(wc);
    return ((vm << 1) | lfsr_t'(^(vm & tap_mask(wc)))) & wc_mask(wc);
  endfunction

  // jump n steps ahead by repeated squaring of the gf(2) step matrix,
  // held as one column per state bit
  function automatic lfsr_t lfsr_leap(input lfsr_t v, input int unsigned n, input wc_t wc);
    lfsr_t       cols [KEY_W];
    lfsr_t       sq   [KEY_W];
    lfsr_t       acc;
    lfsr_t       t;
    int unsigned steps;
    int          i;
    int          j;
    acc   = v & wc_mask(wc);
    steps = n;
    for (i = 0; i < KEY_W; i++) cols[i] = lfsr_next(lfsr_t'(1) << i, wc);
    while (steps != 0) begin
      if (steps[0]) begin
        t = '0;
        for (j = 0; j < KEY_W; j++) if (acc[j]) t ^= cols[j];
        acc = t;
      end
      steps >>= 1;
      for (i = 0; i < KEY_W; i++) begin
        t = '0;
        for (j = 0; j < KEY_W; j++) if (cols[i][j]) t ^= cols[j];
        sq[i] = t;
      end
      for (i = 0; i < KEY_W; i++) cols[i] = sq[i];
    end
    return acc;
  endfunction

  // one accepted byte request: update the tracked state, return the result
  function automatic clear_t descramble(input logic [BYTE_W-1:0] data,
                                        input logic [15:0] fn, input logic sg);
    clear_t             res;
    wc_t                wc;
    logic [FRAME_W-1:0] f;
    logic [BYTE_W-1:0]  ks;
    lfsr_t              v;
    int                 i;
    wc = key_to_wc(key_q);
    ks = '0;
    if (pos_q == 0) begin
      // frame start: reload on frame zero, fast-forward on a skip
      f = fn[FRAME_W-1:0];
      frame_count++;
      if (enable_q) begin
        if (fn != 16'h0000 && f != next_frame_q) begin
          lfsr_q = lfsr_leap(key_q, int'(f) * 8 * FRAME_LEN, wc);
          leap_count++;
        end else if (fn == 16'h0000) begin
          lfsr_q = key_q & wc_mask(wc);
        end
      end
      ks_off_q = sg && (f >= SIG_FRAME_MIN);
      if (ks_off_q) sig_count++;
      next_frame_q = f + 1'b1;
    end
    if (enable_q && !ks_off_q) begin
      v = lfsr_q & wc_mask(wc);
      for (i = 0; i < BYTE_W; i++) begin
        ks = {ks[BYTE_W-2:0], ^(v & tap_mask(wc))};
        v  = lfsr_next(v, wc);
      end
      lfsr_q = v;
    end
    res.clear_byte = data ^ ks;
    res.frame_last = (pos_q == FRAME_LEN - 1);
    pos_q = res.frame_last ? 0 : pos_q + 1;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // one byte request; valid goes up at a falling edge, acceptance is seen
  // at the rising edge where in_stall is low
  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic [15:0] fn,
                           input logic sg);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_payload_byte  <= data;
    in_frame_number  <= fn;
    in_signed_stream <= sg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    clear_q.push_back(descramble(data, fn, sg));
    sent_count++;
  endtask

  // register write once every pending result is back, so the unit is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input lfsr_t data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (clear_q.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_KEY) key_q = data;
    else if (idx == REG_ENABLE) enable_q = data[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random bytes shaped into frames; the frame number only matters on the
  // first byte, so elsewhere it is pure noise
  task automatic send_random(input int n);
    logic [15:0] fn;
    logic        sg;
    int          pick;
    int          k;
    for (k = 0; k < n; k++) begin
      fn = 16'($urandom);
      sg = 1'($urandom);
      if (pos_q == 0) begin
        pick = $urandom_range(99);
        sg   = ($urandom_range(99) < 40);
        if (pick < 55) begin
          // in sequence, sometimes with the end-of-stream bit
          fn = {($urandom_range(7) == 0), next_frame_q};
        end else if (pick < 65) begin
          fn = 16'h0000;
        end else if (pick < 70) begin
          // end-of-stream bit alone: frame number zero but no reload
          fn = 16'h8000;
        end else if (pick < 85) begin
          // short skip
          fn = {1'($urandom), 15'(next_frame_q + $urandom_range(2, 40))};
        end else if (pick < 90) begin
          // anywhere, long fast-forward
          fn = 16'($urandom);
        end else begin
          // around the signature threshold
          fn = {1'($urandom), 15'($urandom_range(32763, 32767))};
        end
      end
      send_byte(8'($urandom), fn, sg);
    end
  endtask

  // receiver stall, redrawn every cycle
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------

  task automatic flag_error(input string what, input int unsigned want_v,
                            input int unsigned got_v);
    err_count++;
    if (err_count <= 10) begin
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : check_results
    clear_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got_count++;
      if (clear_q.size() == 0) begin
        flag_error("result with no request pending", 0, 32'(out_clear_byte));
      end else begin
        want = clear_q.pop_front();
        if (out_clear_byte !== want.clear_byte)
          flag_error("clear_byte", 32'(want.clear_byte), 32'(out_clear_byte));
        if (out_frame_last !== want.frame_last)
          flag_error("frame_last", 32'(want.frame_last), 32'(out_frame_last));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("stream_lfsr_descrambler_unit verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // frame zero reloads the widest key; byte extremes
  task automatic test_frame_zero_reload();
    write_reg(REG_KEY, 24'hFFFFFF);
    write_reg(REG_ENABLE, 24'h000001);
    send_byte(8'h00, 16'h0000, 1'b0);
    send_byte(8'hFF, 16'hFFFF, 1'b1);
    send_byte(8'h80, 16'h0000, 1'b0);
    send_byte(8'h01, 16'h7FFF, 1'b1);
    send_byte(8'h55, 16'h0000, 1'b0);
    send_byte(8'hAA, 16'h0000, 1'b0);
  endtask

  // inside one frame: narrow key takes effect at once, enable off passes
  // bytes, enable back on continues from the held lfsr at 16 bit width
  task automatic test_midframe_config();
    write_reg(REG_KEY, 24'h0000AB);
    send_byte(8'h3C, 16'h0000, 1'b0);
    send_byte(8'hC3, 16'h0000, 1'b0);
    write_reg(REG_ENABLE, 24'h000000);
    send_byte(8'hFF, 16'h0000, 1'b0);
    send_byte(8'h00, 16'h0000, 1'b0);
    write_reg(REG_KEY, 24'h001234);
    write_reg(REG_ENABLE, 24'h000001);
    repeat (6) send_byte(8'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // largest skip lands on a signature frame: keystream off, lfsr still leaps
  task automatic test_signature_leap();
    send_byte(8'hA5, 16'hFFFF, 1'b1);
    send_byte(8'h5A, 16'h0000, 1'b0);
    send_byte(8'hFF, 16'h0001, 1'b0);
  endtask

  task automatic test_random_phase(input int send_gap, input int recv_stall,
                                   input lfsr_t key, input logic en, input int n);
    write_reg(REG_KEY, key);
    write_reg(REG_ENABLE, {23'd0, en});
    gap_pct   = send_gap;
    stall_pct = recv_stall;
    send_random(n);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_KEY;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_payload_byte  = '0;
    in_frame_number  = '0;
    in_signed_stream = 1'b0;
    key_q            = '0;
    enable_q         = 1'b0;
    lfsr_q           = '0;
    next_frame_q     = '0;
    pos_q            = 0;
    ks_off_q         = 1'b0;
    sent_count       = 0;
    frame_count      = 0;
    leap_count       = 0;
    sig_count        = 0;
    gap_pct          = 13;
    stall_pct        = 58;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_frame_zero_reload();
    test_midframe_config();
    test_signature_leap();

    // sender idles rarely, receiver often
    test_random_phase(13, 58, 24'h010000, 1'b1, 100);
    test_random_phase(13, 58, 24'($urandom_range(1, 255)), 1'b1, 100);
    // the other way round
    test_random_phase(58, 13, 24'h00FFFF, 1'b1, 100);
    test_random_phase(58, 13, 24'h000000, 1'b1, 100);
    // no idling at all
    test_random_phase(0, 0, 24'h000100, 1'b0, 100);
    test_random_phase(0, 0, 24'($urandom_range(24'h010000, 24'hFFFFFF)), 1'b1, 100);

    // drain, then give the pipe time to show any stray result
    @(negedge clk);
    in_valid <= 1'b0;
    while (clear_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d byte requests (%0d results) in %0d frames", sent_count, got_count,
             frame_count);
    $display("with %0d fast-forwards and %0d signature frames, 8/16/24 bit keys, enable on/off",
             leap_count, sig_count);
    if (err_count == 0) begin
      $display("stream_lfsr_descrambler_unit verification clean");
    end else begin
      $display("stream_lfsr_descrambler_unit verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sld_pkg.sv
rtl/sld_keystream.sv
rtl/sld_jump.sv
rtl/stream_lfsr_descrambler_unit.sv
tb/tb_top.sv
